/* hw/rtl/tls_pkg.sv */
// Shared constants, codes and control types of the ticket lottery selector.
`default_nettype none

package tls_pkg;

   // Table geometry
   localparam int ENTRIES     = 16;
   localparam int TICKET_BITS = 16;

   // Port field widths
   localparam int CMD_W     = 3;
   localparam int INDEX_W   = 4;
   localparam int LOAD_TK_W = 16;
   localparam int RND_W     = 32;
   localparam int WIN_TK_W  = 16;
   localparam int TOTAL_W   = 20;

   // Derived widths
   localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int SUM_W     = TICKET_BITS + IDX_W;
   localparam int DIV_CNT_W = $clog2(RND_W);
   localparam int CMP_W     = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;

   localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;
   localparam logic [TOTAL_W-1:0]     TOTAL_MAX  = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD        = 3'd0,
      CMD_MARK        = 3'd1,
      CMD_INC         = 3'd2,
      CMD_ROLL        = 3'd3,
      CMD_CLAIM       = 3'd4,
      CMD_RESET_ROUND = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      PASS_INC,
      PASS_SUM,
      PASS_SCAN
   } pass_type;

   typedef enum logic [1:0] {
      FIN_PLAIN,
      FIN_EMPTY,
      FIN_ROLL
   } fin_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INC,
      ST_SUM,
      ST_CHECK,
      ST_DIV,
      ST_SCAN
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic     capture;
      logic     apply;
      logic     pass_clr;
      logic     pass_step;
      pass_type pass_mode;
      logic     div_init;
      logic     div_step;
      logic     finish;
      fin_type  fin_kind;
   } tls_ctl_type;

   // Status from the datapath to the controller
   typedef struct packed {
      cmd_type cmd;
      logic    pass_end;
      logic    div_last;
      logic    total_zero;
   } tls_sts_type;

endpackage

`default_nettype wire

/* hw/rtl/tls_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tls_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/tls_ctrl.sv */
// Controller state machine of the ticket lottery selector.
`default_nettype none

module tls_ctrl
   import tls_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire tls_sts_type sts,
   output tls_ctl_type      ctl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ctl           = '0;
      ctl.pass_mode = PASS_SUM;
      ctl.fin_kind  = FIN_PLAIN;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.cmd)
               CMD_INC: begin
                  ctl.pass_clr = 1'b1;
                  state_in     = ST_INC;
               end
               CMD_ROLL: begin
                  ctl.pass_clr = 1'b1;
                  state_in     = ST_SUM;
               end
               default: begin
                  ctl.apply  = 1'b1;
                  ctl.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            endcase
         end
         ST_INC: begin
            ctl.pass_step = 1'b1;
            ctl.pass_mode = PASS_INC;
            if (sts.pass_end) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_SUM: begin
            ctl.pass_step = 1'b1;
            ctl.pass_mode = PASS_SUM;
            if (sts.pass_end) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.total_zero) begin
               ctl.finish   = 1'b1;
               ctl.fin_kind = FIN_EMPTY;
               state_in     = ST_IDLE;
            end else begin
               ctl.div_init = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            if (sts.div_last) begin
               ctl.pass_clr = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl.pass_step = 1'b1;
            ctl.pass_mode = PASS_SCAN;
            if (sts.pass_end) begin
               ctl.finish   = 1'b1;
               ctl.fin_kind = FIN_ROLL;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/tls_datapath.sv */
// Datapath: entry table, ticket sum, bit-serial modulo and winner scan.
`default_nettype none

module tls_datapath
   import tls_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tls_ctl_type          ctl,
   output tls_sts_type               sts,
   input  wire logic [CMD_W-1:0]     req_cmd,
   input  wire logic [INDEX_W-1:0]   req_entry_index,
   input  wire logic [LOAD_TK_W-1:0] req_load_tickets,
   input  wire logic                 req_load_cooldown,
   input  wire logic [RND_W-1:0]     req_random_value,
   output logic                      rsp_strobe,
   output logic                      rsp_status,
   output logic [INDEX_W-1:0]        rsp_winner_index,
   output logic [WIN_TK_W-1:0]       rsp_winner_tickets,
   output logic [TOTAL_W-1:0]        rsp_total_tickets
);

   // Latched item
   cmd_type                cmd_ff;
   logic [INDEX_W-1:0]     idx_ff;
   logic [TICKET_BITS-1:0] ld_tk_ff;
   logic                   ld_cool_ff;

   // Entry flags
   logic [ENTRIES-1:0] used_ff, used_in;
   logic [ENTRIES-1:0] pres_ff, pres_in;
   logic [ENTRIES-1:0] cool_ff, cool_in;
   logic [ENTRIES-1:0] elig;

   // Pass over the table
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] proc_ent;
   logic             proc_vld;
   logic             proc_elig;

   // Sum, modulo and scan
   logic [SUM_W-1:0]     total_ff, total_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [RND_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [SUM_W:0]       rem_shift;
   logic [SUM_W:0]       total_ext;
   logic [SUM_W-1:0]     run_ff, run_in;
   logic [SUM_W-1:0]     run_sum;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     win_idx_ff, win_idx_in;
   logic [TICKET_BITS-1:0] win_tk_ff, win_tk_in;
   logic                 hit;

   // Table memory
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [TICKET_BITS-1:0] wr_data;
   logic [TICKET_BITS-1:0] rd_data;

   // Addressed entry
   logic [IDX_W-1:0] ent_w;
   logic             in_range;

   // Result registers
   logic                rsp_strobe_ff;
   logic                rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]  rsp_win_idx_ff, rsp_win_idx_in;
   logic [WIN_TK_W-1:0] rsp_win_tk_ff, rsp_win_tk_in;
   logic [TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;
   logic [TOTAL_W-1:0]  total_sat;

   assign ent_w    = IDX_W'(idx_ff);
   assign in_range = (32'(idx_ff) < ENTRIES);
   assign elig     = used_ff & pres_ff & ~cool_ff;

   assign proc_ent  = IDX_W'(cnt_ff - CNT_W'(1));
   assign proc_vld  = (cnt_ff != '0);
   assign proc_elig = proc_vld && elig[proc_ent];

   tls_ram #(
      .WIDTH (TICKET_BITS),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Table writes: single-entry commands, or the increment sweep
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ent_w;
      wr_data = '0;
      if (ctl.apply) begin
         case (cmd_ff)
            CMD_LOAD: begin
               wr_en   = in_range;
               wr_data = ld_tk_ff;
            end
            CMD_MARK: begin
               wr_en = in_range && !used_ff[ent_w];
            end
            CMD_CLAIM: begin
               wr_en = in_range && used_ff[ent_w];
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end else if (ctl.pass_step && (ctl.pass_mode == PASS_INC) && proc_elig
                   && (rd_data != TICKET_MAX)) begin
         wr_en   = 1'b1;
         wr_addr = proc_ent;
         wr_data = rd_data + TICKET_BITS'(1);
      end
   end

   // Flag updates
   always_comb begin
      used_in = used_ff;
      pres_in = pres_ff;
      cool_in = cool_ff;
      if (ctl.apply) begin
         case (cmd_ff)
            CMD_LOAD: begin
               if (in_range) begin
                  used_in[ent_w] = 1'b1;
                  cool_in[ent_w] = ld_cool_ff;
                  pres_in[ent_w] = 1'b0;
               end
            end
            CMD_MARK: begin
               if (in_range) begin
                  if (!used_ff[ent_w]) begin
                     used_in[ent_w] = 1'b1;
                     cool_in[ent_w] = 1'b0;
                     pres_in[ent_w] = 1'b1;
                  end else if (!cool_ff[ent_w]) begin
                     pres_in[ent_w] = 1'b1;
                  end
               end
            end
            CMD_CLAIM: begin
               if (in_range && used_ff[ent_w]) begin
                  pres_in[ent_w] = 1'b0;
                  cool_in[ent_w] = 1'b1;
               end
            end
            CMD_RESET_ROUND: begin
               cool_in = '0;
            end
            default: begin
               cool_in = cool_ff;
            end
         endcase
      end
   end

   // Pass counter, total, modulo and scan
   always_comb begin
      cnt_in     = cnt_ff;
      total_in   = total_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      div_cnt_in = div_cnt_ff;
      run_in     = run_ff;
      found_in   = found_ff;
      win_idx_in = win_idx_ff;
      win_tk_in  = win_tk_ff;

      rem_shift = {rem_ff, quo_ff[RND_W-1]};
      total_ext = {1'b0, total_ff};
      run_sum   = run_ff + SUM_W'(rd_data);
      hit       = proc_elig && !found_ff && (run_sum > rem_ff);

      if (ctl.capture) begin
         total_in = '0;
         quo_in   = req_random_value;
      end

      if (ctl.pass_clr) begin
         cnt_in   = '0;
         run_in   = '0;
         found_in = 1'b0;
      end else if (ctl.pass_step) begin
         cnt_in = cnt_ff + CNT_W'(1);
         case (ctl.pass_mode)
            PASS_SUM: begin
               if (proc_elig) begin
                  total_in = total_ff + SUM_W'(rd_data);
               end
            end
            PASS_SCAN: begin
               if (proc_elig && !found_ff) begin
                  run_in = run_sum;
               end
               if (hit) begin
                  found_in   = 1'b1;
                  win_idx_in = proc_ent;
                  win_tk_in  = rd_data;
               end
            end
            default: begin
               total_in = total_ff;
            end
         endcase
      end

      // Restoring division, one quotient bit a cycle; only the remainder is kept
      if (ctl.div_init) begin
         rem_in     = '0;
         div_cnt_in = '0;
      end else if (ctl.div_step) begin
         if (rem_shift >= total_ext) begin
            rem_in = SUM_W'(rem_shift - total_ext);
         end else begin
            rem_in = SUM_W'(rem_shift);
         end
         quo_in     = {quo_ff[RND_W-2:0], 1'b0};
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // Result formation
   always_comb begin
      if (CMP_W'(total_ff) > CMP_W'(TOTAL_MAX)) begin
         total_sat = TOTAL_MAX;
      end else begin
         total_sat = TOTAL_W'(total_ff);
      end
      rsp_status_in  = rsp_status_ff;
      rsp_win_idx_in = rsp_win_idx_ff;
      rsp_win_tk_in  = rsp_win_tk_ff;
      rsp_total_in   = rsp_total_ff;
      if (ctl.finish) begin
         rsp_status_in  = 1'b0;
         rsp_win_idx_in = '0;
         rsp_win_tk_in  = '0;
         rsp_total_in   = '0;
         case (ctl.fin_kind)
            FIN_EMPTY: begin
               rsp_status_in = 1'b1;
            end
            FIN_ROLL: begin
               rsp_win_idx_in = INDEX_W'(win_idx_in);
               rsp_win_tk_in  = WIN_TK_W'(win_tk_in);
               rsp_total_in   = total_sat;
            end
            default: begin
               rsp_status_in = 1'b0;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         pres_ff       <= '0;
         cool_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         used_ff       <= used_in;
         pres_ff       <= pres_in;
         cool_ff       <= cool_in;
         rsp_strobe_ff <= ctl.finish;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff     <= cmd_type'(req_cmd);
         idx_ff     <= req_entry_index;
         ld_tk_ff   <= TICKET_BITS'(req_load_tickets);
         ld_cool_ff <= req_load_cooldown;
      end
      cnt_ff         <= cnt_in;
      total_ff       <= total_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      div_cnt_ff     <= div_cnt_in;
      run_ff         <= run_in;
      found_ff       <= found_in;
      win_idx_ff     <= win_idx_in;
      win_tk_ff      <= win_tk_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_win_idx_ff <= rsp_win_idx_in;
      rsp_win_tk_ff  <= rsp_win_tk_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign sts.cmd        = cmd_ff;
   assign sts.pass_end   = (cnt_ff == CNT_W'(ENTRIES));
   assign sts.div_last   = (div_cnt_ff == DIV_CNT_W'(RND_W - 1));
   assign sts.total_zero = (total_ff == '0);

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_winner_index   = rsp_win_idx_ff;
   assign rsp_winner_tickets = rsp_win_tk_ff;
   assign rsp_total_tickets  = rsp_total_ff;

endmodule

`default_nettype wire

/* hw/rtl/ticket_lottery_selector_unit.sv */
// Top level of the ticket lottery selector: controller, datapath and entry table.
`default_nettype none

// A command is taken at a rising edge with start high and busy low; exactly one
// result follows, shown for a single cycle with rsp_strobe high, and it cannot
// be held off, so the receiver must take it in that cycle. A new command may be
// issued in the cycle that the previous result is shown. Load, mark present,
// claim, reset round and unknown codes finish in the decode state. Increment
// sweeps the ticket table once through its single read port. Roll sweeps the
// table to form the total, reduces random_value modulo that total one bit a
// cycle, then sweeps again for the winner; when the total is zero it ends after
// the first sweep with status set. The result appears in the first cycle in which
// busy is low again.

module ticket_lottery_selector_unit
   import tls_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [CMD_W-1:0]     req_cmd,
   input  wire logic [INDEX_W-1:0]   req_entry_index,
   input  wire logic [LOAD_TK_W-1:0] req_load_tickets,
   input  wire logic                 req_load_cooldown,
   input  wire logic [RND_W-1:0]     req_random_value,
   output logic                      rsp_strobe,
   output logic                      rsp_status,
   output logic [INDEX_W-1:0]        rsp_winner_index,
   output logic [WIN_TK_W-1:0]       rsp_winner_tickets,
   output logic [TOTAL_W-1:0]        rsp_total_tickets
);

   tls_ctl_type ctl;
   tls_sts_type sts;

   tls_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   tls_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_cmd            (req_cmd),
      .req_entry_index    (req_entry_index),
      .req_load_tickets   (req_load_tickets),
      .req_load_cooldown  (req_load_cooldown),
      .req_random_value   (req_random_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_winner_index   (rsp_winner_index),
      .rsp_winner_tickets (rsp_winner_tickets),
      .rsp_total_tickets  (rsp_total_tickets)
   );

endmodule

`default_nettype wire

/* tb/ticket_lottery_selector_unit_tb.sv */
// Self-checking testbench of the ticket lottery selector: directed table, then random commands.
`default_nettype none

module ticket_lottery_selector_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tls_pkg::*;

   // Codes outside the command set
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
   localparam int ITEM_COUNT = 1600;
   localparam int MAX_GAP    = 11;
   localparam int DRAIN_WAIT = 80;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic                status;
      logic [INDEX_W-1:0]  winner_index;
      logic [WIN_TK_W-1:0] winner_tickets;
      logic [TOTAL_W-1:0]  total_tickets;
   } draw_result_type;

   typedef struct {
      logic [CMD_W-1:0]     cmd;
      logic [INDEX_W-1:0]   index;
      logic [LOAD_TK_W-1:0] tickets;
      logic                 cooldown;
      logic [RND_W-1:0]     rnd;
      bit                   typed;
      draw_result_type      result;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [CMD_W-1:0]     req_cmd = '0;
   logic [INDEX_W-1:0]   req_entry_index = '0;
   logic [LOAD_TK_W-1:0] req_load_tickets = '0;
   logic                 req_load_cooldown = 1'b0;
   logic [RND_W-1:0]     req_random_value = '0;
   logic                 rsp_strobe;
   logic                 rsp_status;
   logic [INDEX_W-1:0]   rsp_winner_index;
   logic [WIN_TK_W-1:0]  rsp_winner_tickets;
   logic [TOTAL_W-1:0]   rsp_total_tickets;

   // Predictor copy of the entry table
   logic [TICKET_BITS-1:0] ticket_tbl [ENTRIES];
   logic                   cooldown_tbl [ENTRIES];
   logic                   present_tbl [ENTRIES];
   logic                   used_tbl [ENTRIES];

   draw_result_type pending_draws [$];
   draw_result_type due_draw;
   draw_result_type seen_draw;
   plan_row_type    plan [$];

   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int rolls_won = 0;
   int rolls_empty = 0;
   int burst_left = 0;

   ticket_lottery_selector_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_entry_index    (req_entry_index),
      .req_load_tickets   (req_load_tickets),
      .req_load_cooldown  (req_load_cooldown),
      .req_random_value   (req_random_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_winner_index   (rsp_winner_index),
      .rsp_winner_tickets (rsp_winner_tickets),
      .rsp_total_tickets  (rsp_total_tickets)
   );

   always #10 clock = ~clock;

   function automatic bit is_eligible(input int i);
      return used_tbl[i] && present_tbl[i] && !cooldown_tbl[i];
   endfunction

   // Apply one command to the table copy and return the draw it answers
   function automatic draw_result_type predict_draw(input logic [CMD_W-1:0] cmd,
                                                    input logic [INDEX_W-1:0] index,
                                                    input logic [LOAD_TK_W-1:0] tickets,
                                                    input logic cooldown,
                                                    input logic [RND_W-1:0] rnd);
      draw_result_type res;
      logic [63:0]     total;
      logic [63:0]     target;
      logic [63:0]     running;
      bit              found;
      res = '0;
      total = '0;
      running = '0;
      found = 1'b0;
      case (cmd)
         CMD_LOAD: begin
            used_tbl[index] = 1'b1;
            ticket_tbl[index] = tickets[TICKET_BITS-1:0];
            cooldown_tbl[index] = cooldown;
            present_tbl[index] = 1'b0;
         end
         CMD_MARK: begin
            if (!used_tbl[index]) begin
               used_tbl[index] = 1'b1;
               ticket_tbl[index] = '0;
               cooldown_tbl[index] = 1'b0;
               present_tbl[index] = 1'b1;
            end else if (!cooldown_tbl[index]) begin
               present_tbl[index] = 1'b1;
            end
         end
         CMD_INC: begin
            for (int i = 0; i < ENTRIES; i++)
               if (is_eligible(i) && ticket_tbl[i] != TICKET_MAX)
                  ticket_tbl[i] = ticket_tbl[i] + 1'b1;
         end
         CMD_ROLL: begin
            for (int i = 0; i < ENTRIES; i++)
               if (is_eligible(i)) total += ticket_tbl[i];
            if (total == 0) begin
               res.status = 1'b1;
            end else begin
               target = (64'(rnd) % total) + 1;
               res.total_tickets = (total > TOTAL_MAX) ? TOTAL_MAX : total[TOTAL_W-1:0];
               for (int i = 0; i < ENTRIES; i++) begin
                  if (!found && is_eligible(i)) begin
                     running += ticket_tbl[i];
                     if (running >= target) begin
                        found = 1'b1;
                        res.winner_index = INDEX_W'(i);
                        res.winner_tickets = ticket_tbl[i];
                     end
                  end
               end
            end
         end
         CMD_CLAIM: begin
            if (used_tbl[index]) begin
               present_tbl[index] = 1'b0;
               ticket_tbl[index] = '0;
               cooldown_tbl[index] = 1'b1;
            end
         end
         CMD_RESET_ROUND: begin
            for (int i = 0; i < ENTRIES; i++) cooldown_tbl[i] = 1'b0;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Mostly random waits, with the odd stretch of back-to-back items
   function automatic int draw_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(20, 40);
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic void add_row(input logic [CMD_W-1:0] cmd,
                                   input logic [INDEX_W-1:0] index,
                                   input logic [LOAD_TK_W-1:0] tickets,
                                   input logic cooldown,
                                   input logic [RND_W-1:0] rnd,
                                   input bit typed,
                                   input draw_result_type result);
      plan_row_type row;
      row.cmd = cmd;
      row.index = index;
      row.tickets = tickets;
      row.cooldown = cooldown;
      row.rnd = rnd;
      row.typed = typed;
      row.result = result;
      plan.push_back(row);
   endfunction

   // Present one item, hold it until taken, then queue its draw
   task automatic issue_item(input plan_row_type row, input int gap);
      draw_result_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= row.cmd;
      req_entry_index <= row.index;
      req_load_tickets <= row.tickets;
      req_load_cooldown <= row.cooldown;
      req_random_value <= row.rnd;
      do @(posedge clock); while (busy);
      predicted = predict_draw(row.cmd, row.index, row.tickets, row.cooldown, row.rnd);
      pending_draws.push_back(row.typed ? row.result : predicted);
      items_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         seen_draw = {rsp_status, rsp_winner_index, rsp_winner_tickets, rsp_total_tickets};
         results_seen++;
         if (pending_draws.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("tb: unexpected result status=%0d winner=%0d tickets=%0d total=%0d",
                        seen_draw.status, seen_draw.winner_index,
                        seen_draw.winner_tickets, seen_draw.total_tickets);
         end else begin
            due_draw = pending_draws.pop_front();
            if (due_draw.status == 1'b1) rolls_empty++;
            else if (due_draw.total_tickets != 0) rolls_won++;
            if (seen_draw.status != due_draw.status
                || seen_draw.winner_index != due_draw.winner_index
                || seen_draw.winner_tickets != due_draw.winner_tickets
                || seen_draw.total_tickets != due_draw.total_tickets) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display({"tb: mismatch at %0t expected status=%0d winner=%0d tickets=%0d",
                            " total=%0d, got status=%0d winner=%0d tickets=%0d total=%0d"},
                           $realtime, due_draw.status, due_draw.winner_index,
                           due_draw.winner_tickets, due_draw.total_tickets,
                           seen_draw.status, seen_draw.winner_index,
                           seen_draw.winner_tickets, seen_draw.total_tickets);
            end
         end
      end
   end

   initial begin
      #(12_000_000);
      $display("tb: failure");
      $finish;
   end

   initial begin
      plan_row_type    row;
      draw_result_type none;
      int              pick;
      int              wait_cycles;
      none = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         ticket_tbl[i] = '0;
         cooldown_tbl[i] = 1'b0;
         present_tbl[i] = 1'b0;
         used_tbl[i] = 1'b0;
      end

      // Empty table, saturation, first and last entry, cooldown and spare codes
      add_row(CMD_ROLL, 4'd0, 16'h0000, 1'b0, 32'h0000_0000, 1, '{1'b1, 4'd0, 16'd0, 20'd0});
      add_row(CMD_INC, 4'd0, 16'h0000, 1'b0, 32'h0000_0000, 1, none);
      add_row(CMD_LOAD, 4'd0, 16'hFFFF, 1'b0, 32'h0000_0000, 1, none);
      add_row(CMD_MARK, 4'd0, 16'h0000, 1'b0, 32'h0000_0000, 1, none);
      add_row(CMD_INC, 4'd0, 16'h0000, 1'b0, 32'h0000_0000, 1, none);
      add_row(CMD_ROLL, 4'd0, 16'h0000, 1'b0, 32'hFFFF_FFFF, 1,
              '{1'b0, 4'd0, 16'hFFFF, 20'd65535});
      add_row(CMD_LOAD, 4'd15, 16'hFFFF, 1'b0, 32'h0000_0000, 1, none);
      add_row(CMD_MARK, 4'd15, 16'h0000, 1'b0, 32'h0000_0000, 1, none);
      add_row(CMD_ROLL, 4'd0, 16'h0000, 1'b0, 32'h0000_FFFF, 1,
              '{1'b0, 4'd15, 16'hFFFF, 20'd131070});
      add_row(CMD_CLAIM, 4'd0, 16'h0000, 1'b0, 32'h0000_0000, 1, none);
      add_row(CMD_ROLL, 4'd0, 16'h0000, 1'b0, 32'h0000_0000, 1,
              '{1'b0, 4'd15, 16'hFFFF, 20'd65535});
      add_row(CMD_MARK, 4'd0, 16'h0000, 1'b0, 32'h0000_0000, 0, none);
      add_row(CMD_ROLL, 4'd0, 16'h0000, 1'b0, 32'h1234_5678, 0, none);
      add_row(CMD_RESET_ROUND, 4'd0, 16'h0000, 1'b0, 32'h0000_0000, 1, none);
      add_row(CMD_MARK, 4'd0, 16'h0000, 1'b0, 32'h0000_0000, 0, none);
      add_row(CMD_LOAD, 4'd3, 16'h0000, 1'b1, 32'h0000_0000, 1, none);
      add_row(CMD_MARK, 4'd3, 16'h0000, 1'b0, 32'h0000_0000, 0, none);
      add_row(CMD_CLAIM, 4'd7, 16'h0000, 1'b0, 32'h0000_0000, 0, none);
      add_row(CMD_MARK, 4'd9, 16'h0000, 1'b0, 32'h0000_0000, 0, none);
      add_row(CMD_INC, 4'd0, 16'h0000, 1'b0, 32'h0000_0000, 0, none);
      add_row(CMD_ROLL, 4'd0, 16'h0000, 1'b0, 32'h0000_0001, 0, none);
      add_row(CMD_SPARE_LO, 4'd5, 16'h1234, 1'b1, 32'hDEAD_BEEF, 1, none);
      add_row(CMD_SPARE_HI, 4'd15, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1, none);
      add_row(CMD_LOAD, 4'd15, 16'h0000, 1'b0, 32'h0000_0000, 1, none);
      add_row(CMD_CLAIM, 4'd0, 16'h0000, 1'b0, 32'h0000_0000, 0, none);
      add_row(CMD_CLAIM, 4'd9, 16'h0000, 1'b0, 32'h0000_0000, 0, none);
      add_row(CMD_ROLL, 4'd0, 16'h0000, 1'b0, 32'hFFFF_FFFF, 1, '{1'b1, 4'd0, 16'd0, 20'd0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k]) issue_item(plan[k], draw_gap());

      // Random commands, weighted towards building and drawing rounds
      for (int n = 0; n < ITEM_COUNT; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) row.cmd = CMD_LOAD;
         else if (pick < 40) row.cmd = CMD_MARK;
         else if (pick < 52) row.cmd = CMD_INC;
         else if (pick < 80) row.cmd = CMD_ROLL;
         else if (pick < 89) row.cmd = CMD_CLAIM;
         else if (pick < 95) row.cmd = CMD_RESET_ROUND;
         else row.cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
         row.index = INDEX_W'($urandom_range(0, ENTRIES - 1));
         pick = $urandom_range(0, 3);
         if (pick < 2) row.tickets = LOAD_TK_W'($urandom_range(0, 15));
         else if (pick == 2) row.tickets = LOAD_TK_W'($urandom);
         else row.tickets = LOAD_TK_W'($urandom_range(16'hFFF0, 16'hFFFF));
         row.cooldown = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         if (pick == 0) row.rnd = '0;
         else if (pick == 1) row.rnd = '1;
         else row.rnd = $urandom;
         row.typed = 1'b0;
         row.result = none;
         issue_item(row, draw_gap());
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (pending_draws.size() != 0 && wait_cycles < 1000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_draws.size() != 0) begin
         $display("tb: %0d results never arrived", pending_draws.size());
         errors += pending_draws.size();
      end

      $display("tb: %0d items issued, %0d results checked, %0d errors",
               items_sent, results_seen, errors);
      $display("tb: rolls with a winner %0d, rolls on an empty table %0d",
               rolls_won, rolls_empty);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
